### rtl/akd_pkg.sv
// shared types, constants and lookup tables for the escape key decoder
// no dependencies; imported by the parser and the top level
package akd_pkg;

  localparam int MAX_SEQ_BYTES = 7;
  localparam int CNT_W = $clog2(MAX_SEQ_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_SEQ_BYTES);

  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] CSI_BYTE    = 8'h9b;
  localparam logic [7:0] DEL_BYTE    = 8'h7f;
  localparam logic [7:0] BS_BYTE     = 8'h08;
  localparam logic [7:0] TAB_BYTE    = 8'h09;
  localparam logic [7:0] LF_BYTE     = 8'h0a;
  localparam logic [7:0] CR_BYTE     = 8'h0d;
  localparam logic [7:0] SPACE_BYTE  = 8'h20;
  localparam logic [7:0] CTRL_OFFSET = 8'h60;

  localparam logic [7:0] K_UP     = 8'd0;
  localparam logic [7:0] K_DOWN   = 8'd1;
  localparam logic [7:0] K_LEFT   = 8'd2;
  localparam logic [7:0] K_RIGHT  = 8'd3;
  localparam logic [7:0] K_HOME   = 8'd4;
  localparam logic [7:0] K_END    = 8'd5;
  localparam logic [7:0] K_DC     = 8'd6;
  localparam logic [7:0] K_PPAGE  = 8'd7;
  localparam logic [7:0] K_NPAGE  = 8'd8;
  localparam logic [7:0] K_INSERT = 8'd9;
  localparam logic [7:0] K_F1     = 8'd10;

  typedef enum logic [1:0] {
    CLS_RAW   = 2'd0,
    CLS_CTRL  = 2'd1,
    CLS_NAMED = 2'd2
  } key_class_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ESC  = 4'd1,
    PH_SEL  = 4'd2,
    PH_FX   = 4'd3,
    PH_DBL  = 4'd4,
    PH_Z1   = 4'd5,
    PH_Z2   = 4'd6,
    PH_ZQ   = 4'd7,
    PH_N1   = 4'd8,
    PH_N2   = 4'd9
  } phase_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] key;
  } key_hit_t;

  // words produced by one input item, word 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    key_class_t                      cls;
    logic [MAX_SEQ_BYTES-1:0][7:0]   bytes;
  } burst_t;

  // SS3 final byte
  function automatic key_hit_t fx_lookup(input logic [7:0] c);
    key_hit_t r;
    r.hit = 1'b1;
    r.key = K_F1;
    case (c)
      "P":     r.key = K_F1;
      "Q":     r.key = K_F1 + 8'd1;
      "w":     r.key = K_F1 + 8'd2;
      "x":     r.key = K_F1 + 8'd3;
      "t":     r.key = K_F1 + 8'd4;
      "u":     r.key = K_F1 + 8'd5;
      "q":     r.key = K_F1 + 8'd6;
      "r":     r.key = K_F1 + 8'd7;
      "p":     r.key = K_F1 + 8'd8;
      "M":     r.key = K_F1 + 8'd9;
      "A":     r.key = K_F1 + 8'd10;
      "B":     r.key = K_F1 + 8'd11;
      "H":     r.key = K_HOME;
      "F":     r.key = K_END;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // single final byte right after the introducer
  function automatic key_hit_t tri_lookup(input logic [7:0] c);
    key_hit_t r;
    r.hit = 1'b1;
    r.key = K_UP;
    case (c)
      "4":     r.key = K_DC;
      "A":     r.key = K_UP;
      "B":     r.key = K_DOWN;
      "C":     r.key = K_RIGHT;
      "D":     r.key = K_LEFT;
      "F":     r.key = K_END;
      "H":     r.key = K_HOME;
      "K":     r.key = K_END;
      "P":     r.key = K_DC;
      "?":     r.key = K_PPAGE;
      "/":     r.key = K_NPAGE;
      "@":     r.key = K_INSERT;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // numeric code before '~'
  function automatic key_hit_t tilde_lookup(input logic [6:0] v);
    key_hit_t r;
    r.hit = 1'b1;
    r.key = K_HOME;
    case (v)
      7'd1, 7'd7: r.key = K_HOME;
      7'd3:       r.key = K_DC;
      7'd5:       r.key = K_PPAGE;
      7'd6:       r.key = K_NPAGE;
      7'd8:       r.key = K_END;
      7'd17:      r.key = K_F1 + 8'd5;
      7'd18:      r.key = K_F1 + 8'd6;
      7'd19:      r.key = K_F1 + 8'd7;
      7'd20:      r.key = K_F1 + 8'd8;
      7'd21:      r.key = K_F1 + 8'd9;
      7'd23:      r.key = K_F1 + 8'd10;
      7'd24:      r.key = K_F1 + 8'd11;
      default:    r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### rtl/akd_if.sv
// valid/ready channel interfaces for the escape key decoder
// input channel carries kind and byte_value, result channel the decoded key
interface akd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface akd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_class;
  logic [7:0] key_value;
  logic       last;

  modport source (output valid, output key_class, output key_value, output last, input ready);
  modport sink   (input valid, input key_class, input key_value, input last, output ready);
endinterface

### rtl/ansi_escape_key_decoder.sv
// top level of the terminal escape key decoder
// uses akd_pkg, the akd_in_if / akd_out_if channels and the akd_parse parser
//
// in_if carries one word per transfer: kind 0 is a console byte in
// byte_value, kind 1 means the inter-byte timeout ran out. out_if carries
// decoded words: key_class (raw, ctrl letter, named key), key_value and
// last, which marks the final word caused by one input word.
// Both channels transfer when valid and ready are high at a rising edge.
// A word is decoded in the cycle it is accepted and lands in a burst
// register; from there the first result moves into the output register
// once that is free, and the output register drives out_if.
// Plain bytes and named keys give one result, and while out_if.ready stays
// high the block takes one word per cycle. A mismatch or timeout flushes up
// to seven buffered bytes, one per ready cycle out of the burst register,
// and input stays stalled until the last of them moves to the output register.
// If the receiver holds ready low the output register holds its word and
// the burst register fills, after which in_if.ready drops.
// Synchronous reset (rst_n low) returns the parser to idle with an empty
// buffer and clears all pending results.
module ansi_escape_key_decoder (
  input  logic          clk,
  input  logic          rst_n,
  akd_in_if.sink        in_if,
  akd_out_if.source     out_if
);
  import akd_pkg::*;

  burst_t                         res;
  logic [CNT_W-1:0]               burst_cnt_r, burst_cnt_nxt;
  key_class_t                     burst_cls_r, burst_cls_nxt;
  logic [MAX_SEQ_BYTES-1:0][7:0]  burst_r, burst_nxt;

  logic       out_valid_r;
  key_class_t out_cls_r;
  logic [7:0] out_value_r;
  logic       out_last_r;

  logic in_fire;
  logic out_free;
  logic pop;

  assign out_free    = !out_valid_r || out_if.ready;
  assign pop         = out_free && (burst_cnt_r != '0);
  assign in_if.ready = (burst_cnt_r == '0) || (burst_cnt_r == CNT_W'(1) && out_free);
  assign in_fire     = in_if.valid && in_if.ready;

  akd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .kind       (in_if.kind),
    .byte_value (in_if.byte_value),
    .res        (res)
  );

  always_comb begin
    burst_cnt_nxt = burst_cnt_r;
    burst_cls_nxt = burst_cls_r;
    burst_nxt     = burst_r;
    if (in_fire) begin
      burst_cnt_nxt = res.count;
      burst_cls_nxt = res.cls;
      burst_nxt     = res.bytes;
    end else if (pop) begin
      burst_cnt_nxt = burst_cnt_r - CNT_W'(1);
      for (int i = 0; i < MAX_SEQ_BYTES - 1; i++) begin
        burst_nxt[i] = burst_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      burst_cnt_r <= burst_cnt_nxt;
      if (pop) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    burst_cls_r <= burst_cls_nxt;
    burst_r     <= burst_nxt;
    if (pop) begin
      out_cls_r   <= burst_cls_r;
      out_value_r <= burst_r[0];
      out_last_r  <= (burst_cnt_r == CNT_W'(1));
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.key_class = out_cls_r;
  assign out_if.key_value = out_value_r;
  assign out_if.last      = out_last_r;

  // a new word only enters once the burst is drained or draining its last
  a_in_burst_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (burst_cnt_r == '0) || (burst_cnt_r == CNT_W'(1) && out_free))
    else $error("input accepted over undrained burst");

  // a word shown without last always has a follower queued
  a_not_last_has_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (burst_cnt_r != '0))
    else $error("non-final word with empty burst");

  // multi-word bursts are raw flushes
  a_multi_is_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (burst_cnt_r > CNT_W'(1)) |-> (burst_cls_r == CLS_RAW))
    else $error("multi-word burst not raw");

  // popping the last burst word with no new input leaves it empty
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !in_fire && burst_cnt_r == CNT_W'(1)) |=> (burst_cnt_r == '0))
    else $error("burst count not drained");

endmodule

### rtl/akd_parse.sv
// sequence parser: phase, pending byte buffer and number accumulator
// decodes one word per cycle, when fire is high, into a burst of result words; uses akd_pkg
module akd_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  logic           kind,
  input  logic [7:0]     byte_value,
  output akd_pkg::burst_t res
);
  import akd_pkg::*;

  phase_t                         phase_r, phase_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [6:0]                     acc_r, acc_nxt;
  logic [MAX_SEQ_BYTES-1:0][7:0]  pending_r;

  logic             push;
  logic [IDX_W-1:0] wr_idx;
  logic             room;
  logic             is_digit;
  logic [3:0]       digit;
  logic [6:0]       acc_x10;
  logic [6:0]       z_sum;
  logic             do_flush, do_flush_t, do_named;
  logic [7:0]       key;
  logic [7:0]       c_mapped;
  key_hit_t         fx_hit, tri_hit, tl_hit;
  logic [MAX_SEQ_BYTES-1:0][7:0] flush_bytes;
  logic [CNT_W-1:0] flush_n;

  assign c_mapped = (byte_value == DEL_BYTE) ? BS_BYTE : byte_value;
  assign is_digit = (byte_value >= "0") && (byte_value <= "9");
  assign digit    = byte_value[3:0];
  assign acc_x10  = 7'({acc_r, 3'b000} + {acc_r, 1'b0});
  assign z_sum    = acc_r + 7'(digit);
  assign room     = count_r < CNT_W'(MAX_SEQ_BYTES);
  assign fx_hit   = fx_lookup(byte_value);
  assign tri_hit  = tri_lookup(byte_value);
  assign tl_hit   = tilde_lookup(acc_r);

  // buffered bytes followed by the current one
  always_comb begin
    for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
      flush_bytes[i] = (CNT_W'(i) < count_r) ? pending_r[i] : byte_value;
    end
    flush_n = room ? count_r + CNT_W'(1) : count_r;
  end

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    push       = 1'b0;
    wr_idx     = count_r[IDX_W-1:0];
    do_flush   = 1'b0;
    do_flush_t = 1'b0;
    do_named   = 1'b0;
    key        = K_UP;
    res.count  = '0;
    res.cls    = CLS_RAW;
    res.bytes  = flush_bytes;

    if (phase_r == PH_IDLE || phase_r > PH_N2) begin
      phase_nxt = PH_IDLE;
      count_nxt = '0;
      if (!kind) begin
        if (byte_value == ESC_BYTE || byte_value == CSI_BYTE) begin
          push      = 1'b1;
          wr_idx    = '0;
          count_nxt = CNT_W'(1);
          phase_nxt = (byte_value == ESC_BYTE) ? PH_ESC : PH_SEL;
        end else begin
          res.count = CNT_W'(1);
          if (c_mapped < SPACE_BYTE && c_mapped != TAB_BYTE && c_mapped != BS_BYTE &&
              c_mapped != LF_BYTE && c_mapped != CR_BYTE) begin
            res.cls      = CLS_CTRL;
            res.bytes[0] = c_mapped + CTRL_OFFSET;
          end else begin
            res.cls      = CLS_RAW;
            res.bytes[0] = c_mapped;
          end
        end
      end
    end else if (kind) begin
      do_flush_t = 1'b1;
    end else begin
      push = room;
      if (room) count_nxt = count_r + CNT_W'(1);
      unique case (phase_r)
        PH_ESC: begin
          if (byte_value == "O") phase_nxt = PH_FX;
          else if (byte_value == "[") phase_nxt = PH_SEL;
          else do_flush = 1'b1;
        end
        PH_FX: begin
          if (fx_hit.hit) begin
            do_named = 1'b1;
            key      = fx_hit.key;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_SEL: begin
          if (tri_hit.hit) begin
            do_named = 1'b1;
            key      = tri_hit.key;
          end else if (byte_value == "[") begin
            phase_nxt = PH_DBL;
          end else if (byte_value == "O") begin
            phase_nxt = PH_FX;
          end else if (byte_value == "0") begin
            phase_nxt = PH_Z1;
          end else if (is_digit) begin
            acc_nxt   = 7'(digit);
            phase_nxt = PH_N1;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_DBL: begin
          if (byte_value >= "A" && byte_value <= "E") begin
            do_named = 1'b1;
            key      = K_F1 + (byte_value - "A");
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_Z1: begin
          if (byte_value == "0" || byte_value == "1") begin
            acc_nxt   = byte_value[0] ? 7'd10 : 7'd0;
            phase_nxt = PH_Z2;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_Z2: begin
          if (is_digit && z_sum >= 7'd1 && z_sum <= 7'd12) begin
            acc_nxt   = z_sum;
            phase_nxt = PH_ZQ;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_ZQ: begin
          if (byte_value == "q" && acc_r >= 7'd1 && acc_r <= 7'd12) begin
            do_named = 1'b1;
            key      = K_F1 + 8'(acc_r) - 8'd1;
          end else begin
            do_flush = 1'b1;
          end
        end
        PH_N1, PH_N2: begin
          if (phase_r == PH_N1 && is_digit) begin
            acc_nxt   = acc_x10 + 7'(digit);
            phase_nxt = PH_N2;
          end else if (byte_value == "~" && tl_hit.hit) begin
            do_named = 1'b1;
            key      = tl_hit.key;
          end else begin
            do_flush = 1'b1;
          end
        end
        default: do_flush = 1'b1;
      endcase
    end

    if (do_flush || do_flush_t || do_named) begin
      phase_nxt = PH_IDLE;
      count_nxt = '0;
      acc_nxt   = '0;
    end
    if (do_flush) begin
      res.count = flush_n;
    end else if (do_flush_t) begin
      res.count = count_r;
    end else if (do_named) begin
      res.count    = CNT_W'(1);
      res.cls      = CLS_NAMED;
      res.bytes[0] = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      acc_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // pending buffer holds the introducer and the sequence bytes after it
  always_ff @(posedge clk) begin
    if (fire && push) begin
      pending_r[wr_idx] <= byte_value;
    end
  end

endmodule

### bench/akd_checker.sv
// scoreboard for the escape key decoder: watches both channels, predicts
// the decoded words from the accepted input words and compares them in order
// depends on akd_pkg and the akd_in_if / akd_out_if interfaces
module akd_checker (
  input  logic clk,
  input  logic rst_n,
  akd_in_if    in_ch,
  akd_out_if   out_ch,
  output int   errors,
  output int   waiting
);
  import akd_pkg::*;

  typedef struct packed {
    key_class_t cls;
    logic [7:0] val;
    logic       last;
  } key_word_t;

  localparam int FX_N  = 14;
  localparam int TRI_N = 12;

  localparam logic [7:0] FX_FINALS [FX_N] = '{
    "P", "Q", "w", "x", "t", "u", "q", "r", "p", "M", "A", "B", "H", "F"
  };
  localparam logic [7:0] FX_KEYS [FX_N] = '{
    K_F1, K_F1 + 8'd1, K_F1 + 8'd2, K_F1 + 8'd3, K_F1 + 8'd4, K_F1 + 8'd5,
    K_F1 + 8'd6, K_F1 + 8'd7, K_F1 + 8'd8, K_F1 + 8'd9, K_F1 + 8'd10,
    K_F1 + 8'd11, K_HOME, K_END
  };
  localparam logic [7:0] TRI_FINALS [TRI_N] = '{
    "4", "A", "B", "C", "D", "F", "H", "K", "P", "?", "/", "@"
  };
  localparam logic [7:0] TRI_KEYS [TRI_N] = '{
    K_DC, K_UP, K_DOWN, K_RIGHT, K_LEFT, K_END, K_HOME, K_END, K_DC,
    K_PPAGE, K_NPAGE, K_INSERT
  };

  key_word_t  expected_keys[$];
  phase_t     seq_phase;
  logic [7:0] held_bytes [MAX_SEQ_BYTES];
  int         held_count;
  logic [6:0] num_value;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic back_to_idle();
    seq_phase  = PH_IDLE;
    held_count = 0;
    num_value  = '0;
  endtask

  task automatic emit_key(input key_class_t cls, input logic [7:0] val, input logic lst);
    key_word_t w;
    w.cls  = cls;
    w.val  = val;
    w.last = lst;
    expected_keys.push_back(w);
  endtask

  task automatic emit_named(input logic [7:0] key);
    emit_key(CLS_NAMED, key, 1'b1);
    back_to_idle();
  endtask

  // buffered bytes go out raw, oldest first
  task automatic flush_held();
    for (int i = 0; i < held_count; i++)
      emit_key(CLS_RAW, held_bytes[i], i == held_count - 1);
    back_to_idle();
  endtask

  task automatic hold_byte(input logic [7:0] b);
    if (held_count < MAX_SEQ_BYTES) begin
      held_bytes[held_count] = b;
      held_count++;
    end
  endtask

  function automatic int find_key(input logic [7:0] b, input logic is_fx);
    int n;
    n = is_fx ? FX_N : TRI_N;
    for (int i = 0; i < n; i++) begin
      if (is_fx && FX_FINALS[i] == b)
        return int'(FX_KEYS[i]);
      if (!is_fx && TRI_FINALS[i] == b)
        return int'(TRI_KEYS[i]);
    end
    return -1;
  endfunction

  function automatic int tilde_key(input logic [6:0] v);
    if (v == 7'd1 || v == 7'd7) return int'(K_HOME);
    if (v == 7'd3) return int'(K_DC);
    if (v == 7'd5) return int'(K_PPAGE);
    if (v == 7'd6) return int'(K_NPAGE);
    if (v == 7'd8) return int'(K_END);
    if (v >= 7'd17 && v <= 7'd21) return int'(K_F1) + 5 + int'(v) - 17;
    if (v == 7'd23 || v == 7'd24) return int'(K_F1) + 10 + int'(v) - 23;
    return -1;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic finish_tilde(input logic [7:0] b);
    int key;
    key = (b == "~") ? tilde_key(num_value) : -1;
    if (key >= 0)
      emit_named(8'(key));
    else
      flush_held();
  endtask

  task automatic decode_input(input logic k, input logic [7:0] c);
    logic [7:0] b;
    int         key;
    b = c;
    if (seq_phase == PH_IDLE) begin
      held_count = 0;
      if (k)
        return;
      if (b == ESC_BYTE || b == CSI_BYTE) begin
        hold_byte(b);
        seq_phase = (b == ESC_BYTE) ? PH_ESC : PH_SEL;
        return;
      end
      if (b == DEL_BYTE)
        b = BS_BYTE;
      if (b < SPACE_BYTE && b != TAB_BYTE && b != BS_BYTE && b != LF_BYTE && b != CR_BYTE)
        emit_key(CLS_CTRL, b + CTRL_OFFSET, 1'b1);
      else
        emit_key(CLS_RAW, b, 1'b1);
      return;
    end
    if (k) begin
      flush_held();
      return;
    end
    // each byte inside a sequence is kept, while there is room, for a possible raw flush
    hold_byte(b);
    case (seq_phase)
      PH_ESC: begin
        if (b == "O") seq_phase = PH_FX;
        else if (b == "[") seq_phase = PH_SEL;
        else flush_held();
      end
      PH_FX: begin
        key = find_key(b, 1'b1);
        if (key >= 0) emit_named(8'(key));
        else flush_held();
      end
      PH_SEL: begin
        key = find_key(b, 1'b0);
        if (key >= 0) emit_named(8'(key));
        else if (b == "[") seq_phase = PH_DBL;
        else if (b == "O") seq_phase = PH_FX;
        else if (b == "0") seq_phase = PH_Z1;
        else if (b >= "1" && b <= "9") begin
          num_value = 7'(b - "0");
          seq_phase = PH_N1;
        end else flush_held();
      end
      PH_DBL: begin
        if (b >= "A" && b <= "E") emit_named(K_F1 + (b - "A"));
        else flush_held();
      end
      PH_Z1: begin
        if (b == "0" || b == "1") begin
          num_value = 7'((b - "0") * 10);
          seq_phase = PH_Z2;
        end else flush_held();
      end
      PH_Z2: begin
        // zero or anything above twelve fails right at the second digit
        if (is_digit(b)) begin
          num_value = 7'(int'(num_value) + int'(b - "0"));
          if (num_value >= 7'd1 && num_value <= 7'd12) seq_phase = PH_ZQ;
          else flush_held();
        end else flush_held();
      end
      PH_ZQ: begin
        if (b == "q") emit_named(K_F1 + 8'(num_value) - 8'd1);
        else flush_held();
      end
      PH_N1: begin
        if (is_digit(b)) begin
          num_value = 7'(int'(num_value) * 10 + int'(b - "0"));
          seq_phase = PH_N2;
        end else finish_tilde(b);
      end
      PH_N2: finish_tilde(b);
      default: back_to_idle();
    endcase
  endtask

  always @(posedge clk) begin
    key_word_t w;
    if (!rst_n) begin
      back_to_idle();
      expected_keys.delete();
      errors = 0;
    end else begin
      // a result never comes from the word accepted at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          report_mismatch("unexpected word, value", int'(out_ch.key_value), -1);
        end else begin
          w = expected_keys.pop_front();
          if (out_ch.key_class != w.cls)
            report_mismatch("key_class", int'(out_ch.key_class), int'(w.cls));
          if (out_ch.key_value != w.val)
            report_mismatch("key_value", int'(out_ch.key_value), int'(w.val));
          if (out_ch.last != w.last)
            report_mismatch("last", int'(out_ch.last), int'(w.last));
        end
      end
      if (in_ch.valid && in_ch.ready)
        decode_input(in_ch.kind, in_ch.byte_value);
    end
    waiting = expected_keys.size();
  end

endmodule

### bench/tb_ansi_escape_key_decoder.sv
// top of the escape key decoder bench: clock, reset, key sequence stimulus
// and the verdict; checking is done by akd_checker beside the block
// depends on akd_pkg, akd_in_if / akd_out_if, ansi_escape_key_decoder
module tb_ansi_escape_key_decoder;
  import akd_pkg::*;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   TAIL_CYCLES  = 30;

  localparam int TRI_W = 12;
  localparam logic [8*TRI_W-1:0] TRI_LIST = "4ABCDFHKP?/@";
  localparam int FX_W = 14;
  localparam logic [8*FX_W-1:0] FX_LIST = "PQwxtuqrpMABHF";
  localparam int TILDE_CODES [13] = '{1, 3, 5, 6, 7, 8, 17, 18, 19, 20, 21, 23, 24};

  logic clk;
  logic rst_n;
  int   errors;
  int   waiting;
  int   cycle_count;
  int   bytes_sent;
  int   gap_pct;
  int   stall_pct;
  logic hold_go;
  logic hold_taken;
  int   hold_left;

  akd_in_if  in_ch ();
  akd_out_if out_ch ();

  ansi_escape_key_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  akd_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .waiting (waiting)
  );

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_BYTE;
    in_ch.byte_value  = 8'h00;
    out_ch.ready      = 1'b0;
    gap_pct           = 0;
    stall_pct         = 0;
    hold_go           = 1'b0;
    hold_taken        = 1'b0;
    hold_left         = 0;
    cycle_count       = 0;
    bytes_sent        = 0;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // called and returns at a falling edge; holds the word until taken
  task automatic put_word(input logic k, input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (k == KIND_BYTE)
      bytes_sent++;
    @(negedge clk);
  endtask

  task automatic type_text(input string s);
    for (int i = 0; i < s.len(); i++)
      put_word(KIND_BYTE, s[i]);
  endtask

  // one key sequence with random content, sometimes corrupted or cut short
  task automatic send_sequence();
    logic [8:0] seq[$];
    logic [7:0] intro;
    int         cat;
    int         v;
    int         pos;
    int         r;
    intro = $urandom_range(1) ? ESC_BYTE : CSI_BYTE;
    cat   = $urandom_range(5);
    seq.push_back({KIND_BYTE, intro});
    if (intro == ESC_BYTE && !(cat == 1 && $urandom_range(1)))
      seq.push_back({KIND_BYTE, "["});
    case (cat)
      0: begin
        v = $urandom_range(TRI_W - 1);
        seq.push_back({KIND_BYTE, TRI_LIST[8*v +: 8]});
      end
      1: begin
        v = $urandom_range(FX_W - 1);
        seq.push_back({KIND_BYTE, "O"});
        seq.push_back({KIND_BYTE, FX_LIST[8*v +: 8]});
      end
      2: begin
        seq.push_back({KIND_BYTE, "["});
        seq.push_back({KIND_BYTE, 8'("A" + $urandom_range(4))});
      end
      3: begin
        v = ($urandom_range(3) == 0) ? $urandom_range(19) : $urandom_range(1, 12);
        seq.push_back({KIND_BYTE, "0"});
        seq.push_back({KIND_BYTE, 8'("0" + v / 10)});
        seq.push_back({KIND_BYTE, 8'("0" + v % 10)});
        seq.push_back({KIND_BYTE, "q"});
      end
      4: begin
        v = ($urandom_range(3) == 0) ? $urandom_range(1, 99) : TILDE_CODES[$urandom_range(12)];
        if (v >= 10)
          seq.push_back({KIND_BYTE, 8'("0" + v / 10)});
        seq.push_back({KIND_BYTE, 8'("0" + v % 10)});
        seq.push_back({KIND_BYTE, "~"});
      end
      default: begin
        repeat ($urandom_range(1, 3))
          seq.push_back({KIND_BYTE, 8'($urandom_range(255))});
      end
    endcase
    r = $urandom_range(99);
    if (r < 12) begin
      pos = $urandom_range(1, seq.size() - 1);
      seq[pos] = {KIND_BYTE, 8'($urandom_range(255))};
    end else if (r < 22) begin
      // cut short by the inter-byte timeout
      pos = $urandom_range(1, seq.size() - 1);
      while (seq.size() > pos)
        void'(seq.pop_back());
      seq.push_back({KIND_TIMEOUT, 8'($urandom_range(255))});
    end
    foreach (seq[i])
      put_word(seq[i][8], seq[i][7:0]);
  endtask

  task automatic run_random(input int n_bytes);
    int goal;
    int r;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      r = $urandom_range(99);
      if (r < 18)
        put_word(KIND_BYTE, 8'($urandom_range(255)));
      else if (r < 22)
        put_word(KIND_TIMEOUT, 8'($urandom_range(255)));
      else
        send_sequence();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // plain byte extremes and a timeout with nothing buffered
    put_word(KIND_BYTE, 8'h00);
    put_word(KIND_BYTE, 8'hff);
    put_word(KIND_BYTE, DEL_BYTE);
    put_word(KIND_TIMEOUT, 8'hff);
    // ss3 with a bracket is a mismatch
    put_word(KIND_BYTE, ESC_BYTE);
    type_text("O[");
    // number with no table entry
    put_word(KIND_BYTE, CSI_BYTE);
    type_text("2~");
    // zero function number fails at the second digit
    put_word(KIND_BYTE, ESC_BYTE);
    type_text("[000");
    put_word(KIND_BYTE, ESC_BYTE);
    type_text("[012q");
    // timeout in the middle of a sequence
    put_word(KIND_BYTE, ESC_BYTE);
    type_text("[1");
    put_word(KIND_TIMEOUT, 8'h00);

    run_random(85);
    gap_pct = 66;
    run_random(85);
    gap_pct   = 0;
    stall_pct = 66;
    run_random(85);
    gap_pct   = 8;
    stall_pct = 8;
    run_random(85);
    gap_pct   = 0;
    stall_pct = 0;
    hold_go   = 1'b1;
    run_random(80);
    put_word(KIND_TIMEOUT, 8'h00);
    in_ch.valid <= 1'b0;

    while (waiting != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/akd_pkg.sv
rtl/akd_if.sv
rtl/akd_parse.sv
rtl/ansi_escape_key_decoder.sv
bench/akd_checker.sv
bench/tb_ansi_escape_key_decoder.sv
